// ----- rtl/core/octal_escape_decoder_core_assert.svh -----
// assertion macros for the octal escape decoder
`ifndef OCTAL_ESCAPE_DECODER_CORE_ASSERT_SVH
`define OCTAL_ESCAPE_DECODER_CORE_ASSERT_SVH

// clocked property, disabled while reset is held
`define OED_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("octal escape decoder check failed");

// condition that must never be seen
`define OED_ASSERT_NEVER(label, cond) \
  `OED_ASSERT(label, !(cond))

`endif

// ----- rtl/core/oed_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package oed_pkg;

  // character codes
  localparam logic [7:0] BSLASH = 8'h5C;
  localparam logic [7:0] DIGIT0 = 8'h30;
  localparam logic [7:0] DIGIT7 = 8'h37;

  // most result items one input item can cause
  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);
  localparam int unsigned IdxW       = $clog2(MaxResults);

  // escape phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_BS   = 4'b0010,
    PH_D1   = 4'b0100,
    PH_D2   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_data;
  } oed_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_last;
  } oed_out_t;

endpackage

`default_nettype wire

// ----- rtl/core/octal_escape_decoder_core.sv -----
// result items are registered in the result buffer and appear in the cycle after the input item that causes them
// throughput: one input item per cycle while each yields at most one result item and out_stall_i is low;
//   an item with k results (k up to four) holds the input until its results drain from
//   the four-entry result shift buffer, which drains one item per cycle while out_stall_i is low
// reset: asynchronous active low, escape phase idle, digits zero, buffer empty
`timescale 1ns / 1ps
`default_nettype none

module octal_escape_decoder_core (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire oed_pkg::oed_in_t in_data_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output oed_pkg::oed_out_t  out_data_o
);

  import oed_pkg::*;

  phase_e              phase_q, phase_d;
  logic [2:0]          d1_q, d1_d;
  logic [2:0]          d2_q, d2_d;
  logic [7:0]          buf_q [MaxResults];
  logic [7:0]          buf_d [MaxResults];
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                eod_q, eod_d;

  logic                in_acc;
  logic                out_acc;
  logic [7:0]          res_bytes [MaxResults];
  logic [CntW-1:0]     res_cnt;
  logic                flush_cur;
  logic                do_plain;
  logic                is_oct;
  logic                is_bs;
  logic [7:0]          b;

  // handshake
  assign out_valid_o = (cnt_q != '0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign in_stall_o  = (cnt_q > CntW'(1)) || ((cnt_q == CntW'(1)) && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;

  assign b      = in_data_i.in_byte;
  assign is_oct = (b >= DIGIT0) && (b <= DIGIT7);
  assign is_bs  = (b == BSLASH);

  // decode one input item into its list of result bytes and next phase
  always_comb begin
    for (int i = 0; i < MaxResults; i++) begin
      res_bytes[i] = '0;
    end
    res_cnt   = '0;
    phase_d   = phase_q;
    d1_d      = d1_q;
    d2_d      = d2_q;
    flush_cur = 1'b0;
    do_plain  = 1'b0;

    unique case (phase_q)
      PH_IDLE: begin
        do_plain = 1'b1;
      end
      PH_BS: begin
        if (is_oct) begin
          d1_d    = b[2:0];
          phase_d = PH_D1;
        end else if (is_bs) begin
          res_bytes[res_cnt[IdxW-1:0]] = BSLASH;
          res_cnt = res_cnt + CntW'(1);
          phase_d = PH_IDLE;
        end else begin
          flush_cur = 1'b1;
          do_plain  = 1'b1;
        end
      end
      PH_D1: begin
        if (is_oct) begin
          d2_d    = b[2:0];
          phase_d = PH_D2;
        end else begin
          flush_cur = 1'b1;
          do_plain  = 1'b1;
        end
      end
      PH_D2: begin
        if (is_oct) begin
          // d1*64 + d2*8 + d3, modulo 256
          res_bytes[res_cnt[IdxW-1:0]] = {d1_q[1:0], d2_q, b[2:0]};
          res_cnt = res_cnt + CntW'(1);
          phase_d = PH_IDLE;
        end else begin
          flush_cur = 1'b1;
          do_plain  = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    // broken escape: held backslash and digits go out literally
    if (flush_cur) begin
      res_bytes[res_cnt[IdxW-1:0]] = BSLASH;
      res_cnt = res_cnt + CntW'(1);
      if (phase_q == PH_D1 || phase_q == PH_D2) begin
        res_bytes[res_cnt[IdxW-1:0]] = DIGIT0 + {5'd0, d1_q};
        res_cnt = res_cnt + CntW'(1);
      end
      if (phase_q == PH_D2) begin
        res_bytes[res_cnt[IdxW-1:0]] = DIGIT0 + {5'd0, d2_q};
        res_cnt = res_cnt + CntW'(1);
      end
      phase_d = PH_IDLE;
    end

    // byte with no escape pending
    if (do_plain) begin
      if (is_bs) begin
        phase_d = PH_BS;
      end else begin
        res_bytes[res_cnt[IdxW-1:0]] = b;
        res_cnt = res_cnt + CntW'(1);
        phase_d = PH_IDLE;
      end
    end

    // end of data: flush whatever escape is still pending
    if (in_data_i.end_of_data) begin
      if (phase_d != PH_IDLE) begin
        res_bytes[res_cnt[IdxW-1:0]] = BSLASH;
        res_cnt = res_cnt + CntW'(1);
      end
      if (phase_d == PH_D1 || phase_d == PH_D2) begin
        res_bytes[res_cnt[IdxW-1:0]] = DIGIT0 + {5'd0, d1_d};
        res_cnt = res_cnt + CntW'(1);
      end
      if (phase_d == PH_D2) begin
        res_bytes[res_cnt[IdxW-1:0]] = DIGIT0 + {5'd0, d2_d};
        res_cnt = res_cnt + CntW'(1);
      end
      phase_d = PH_IDLE;
    end
  end

  // result buffer: load on a new item, shift down as items drain
  always_comb begin
    cnt_d = cnt_q;
    eod_d = eod_q;
    for (int i = 0; i < MaxResults; i++) begin
      buf_d[i] = buf_q[i];
    end
    if (in_acc) begin
      cnt_d = res_cnt;
      eod_d = in_data_i.end_of_data;
      for (int i = 0; i < MaxResults; i++) begin
        buf_d[i] = res_bytes[i];
      end
    end else if (out_acc) begin
      cnt_d = cnt_q - CntW'(1);
      for (int i = 0; i < MaxResults - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      d1_q    <= '0;
      d2_q    <= '0;
      cnt_q   <= '0;
      eod_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q <= phase_d;
        d1_q    <= d1_d;
        d2_q    <= d2_d;
      end
      cnt_q <= cnt_d;
      eod_q <= eod_d;
    end
  end

  // result bytes, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxResults; i++) begin
      buf_q[i] <= buf_d[i];
    end
  end

  // output item
  assign out_data_o.out_byte    = buf_q[0];
  assign out_data_o.run_last    = (cnt_q == CntW'(1));
  assign out_data_o.string_last = (cnt_q == CntW'(1)) && eod_q;

`include "octal_escape_decoder_core_assert.svh"

  // end of data always leaves the phase idle
  `OED_ASSERT(a_eod_idle, (in_acc && in_data_i.end_of_data) |=> (phase_q == PH_IDLE))
  // end of data always yields at least one result item
  `OED_ASSERT(a_eod_result, (in_acc && in_data_i.end_of_data) |=> out_valid_o)
  // buffer never holds more than MaxResults items
  `OED_ASSERT_NEVER(a_cnt_range, cnt_q > CntW'(MaxResults))
  // an item's results leave back to back once the sink takes them
  `OED_ASSERT(a_run_cont, (out_acc && !out_data_o.run_last) |=> out_valid_o)

endmodule

`default_nettype wire
